FILE: sv/wsp_pkg.sv
// shared types, widths and helpers for the world to screen projection block
// no dependencies

package wsp_pkg;

    localparam int CRD_W   = 32;              // coordinate and coefficient width
    localparam int PROD_W  = 2 * CRD_W;       // full coefficient times coordinate product
    localparam int FLR_W   = PROD_W - 16;     // product after dropping the q16 fraction
    localparam int CLIP_W  = 50;              // clip x, y, w exact sum
    localparam int SIZE_W  = 14;              // viewport size register
    localparam int NUM_W   = CLIP_W + SIZE_W; // |clip| * size
    localparam int DEN_W   = CLIP_W - 1;      // positive w magnitude
    localparam int QUO_W   = 40;              // quotient bits below the clamp
    localparam int FRAC_SH = 15;              // extra fraction bits of 0.5 * size
    localparam int HI_W    = NUM_W - (QUO_W - FRAC_SH);
    localparam int TERM_W  = QUO_W + 2;       // signed, holds +-2^40
    localparam int SUM_W   = 48;              // final pixel sum before saturation
    localparam int DIV_LAT = QUO_W + 3;       // cycles through the scale unit

    localparam logic signed [CLIP_W-1:0] VIS_LIMIT = CLIP_W'(655);
    localparam logic signed [SUM_W-1:0]  HALF_PIX  = SUM_W'(32768);

    typedef enum logic [2:0] {
        CFG_ROW_X_XY = 3'd0,
        CFG_ROW_X_ZT = 3'd1,
        CFG_ROW_Y_XY = 3'd2,
        CFG_ROW_Y_ZT = 3'd3,
        CFG_ROW_W_XY = 3'd4,
        CFG_ROW_W_ZT = 3'd5,
        CFG_SCR_W    = 3'd6,
        CFG_SCR_H    = 3'd7
    } t_cfg_idx;

    // clamp to signed 32 bits
    function automatic logic [CRD_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'(64'sh7FFF_FFFF);
        lo = -SUM_W'(64'sh8000_0000);
        if (v > hi) begin
            return 32'h7FFF_FFFF;
        end else if (v < lo) begin
            return 32'h8000_0000;
        end
        return v[CRD_W-1:0];
    endfunction

endpackage

FILE: sv/wsp_scale.sv
// pipelined scale unit: sign(c) * min(trunc(|c| * size * 2^15 / w), 2^40)
// depends on wsp_pkg; one restoring division step per stage

module wsp_scale import wsp_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [CLIP_W-1:0] i_clip,
    input  logic signed [CLIP_W-1:0] i_w,
    input  logic [SIZE_W-1:0]        i_size,
    output logic signed [TERM_W-1:0] o_term
);

    // stage a: magnitude times size
    logic              r_a_neg;
    logic [NUM_W-1:0]  r_a_num;
    logic [DEN_W-1:0]  r_a_den;
    logic [CLIP_W-1:0] n_mag;

    assign n_mag = i_clip[CLIP_W-1] ? CLIP_W'(-i_clip) : CLIP_W'(i_clip);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_neg <= i_clip[CLIP_W-1];
            r_a_num <= NUM_W'(n_mag) * NUM_W'(i_size);
            r_a_den <= i_w[DEN_W-1:0];
        end
    end

    // division chain, index 0 loaded by the clamp check
    logic [DEN_W-1:0] r_rem   [0:QUO_W];
    logic [QUO_W-1:0] r_low   [0:QUO_W];
    logic [QUO_W-1:0] r_quo   [0:QUO_W];
    logic [DEN_W-1:0] r_den   [0:QUO_W];
    logic             r_neg   [0:QUO_W];
    logic             r_clamp [0:QUO_W];
    logic [HI_W-1:0]  n_hi;
    logic             n_clamp;

    assign n_hi    = r_a_num[NUM_W-1 -: HI_W];
    assign n_clamp = DEN_W'(n_hi) >= r_a_den;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]   <= n_clamp ? '0 : DEN_W'(n_hi);
            r_low[0]   <= {r_a_num[QUO_W-FRAC_SH-1:0], {FRAC_SH{1'b0}}};
            r_quo[0]   <= '0;
            r_den[0]   <= r_a_den;
            r_neg[0]   <= r_a_neg;
            r_clamp[0] <= n_clamp;
        end
    end

    for (genvar k = 0; k < QUO_W; k++) begin : g_step
        logic [DEN_W:0] n_part;
        logic           n_ge;
        assign n_part = {r_rem[k], r_low[k][QUO_W-1]};
        assign n_ge   = n_part >= {1'b0, r_den[k]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]   <= n_ge ? DEN_W'(n_part - {1'b0, r_den[k]}) : DEN_W'(n_part);
                r_low[k+1]   <= {r_low[k][QUO_W-2:0], 1'b0};
                r_quo[k+1]   <= {r_quo[k][QUO_W-2:0], n_ge};
                r_den[k+1]   <= r_den[k];
                r_neg[k+1]   <= r_neg[k];
                r_clamp[k+1] <= r_clamp[k];
            end
        end
    end

    // clamp and sign
    logic [TERM_W-1:0] n_mag_q;
    assign n_mag_q = r_clamp[QUO_W] ? TERM_W'(1) << QUO_W : TERM_W'(r_quo[QUO_W]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_term <= r_neg[QUO_W] ? -$signed(n_mag_q) : $signed(n_mag_q);
        end
    end

endmodule

FILE: sv/world_to_screen_projection.sv
// top level of the world to screen projection pipeline
// depends on wsp_pkg and wsp_scale
//
// channel | dir | fields (low bit first)
// s       | in  | tdata: world_x[31:0], world_y[63:32], world_z[95:64]
// m       | out | tdata: screen_x[31:0], screen_y[63:32]; tuser: visible
// cfg     | in  | i_cfg_idx selects one of eight registers, i_cfg_data 64 bits
//
// one point per cycle while the master side is not stalled; from request to result:
// products, two adder stages, the scale unit
// (one restoring division bit per stage, 40 bits), then the pixel sum.
// the whole pipeline holds while a result waits and the master side is stalled.
// synchronous active low reset clears valid bits and loads register defaults.

module world_to_screen_projection import wsp_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [3*CRD_W-1:0]     i_s_tdata,   // world_x, world_y, world_z
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [2*CRD_W-1:0]     o_m_tdata,   // screen_x, screen_y
    output logic                   o_m_tuser,   // visible
    input  logic                   i_cfg_we,
    input  logic [2:0]             i_cfg_idx,
    input  logic [63:0]            i_cfg_data
);

    localparam int NSTG = 3 + DIV_LAT + 1;

    // configuration registers
    logic [63:0]       r_rx_xy, r_rx_zt, r_ry_xy, r_ry_zt, r_rw_xy, r_rw_zt;
    logic [SIZE_W-1:0] r_scr_w, r_scr_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_xy <= '0;
            r_rx_zt <= '0;
            r_ry_xy <= '0;
            r_ry_zt <= '0;
            r_rw_xy <= '0;
            r_rw_zt <= '0;
            r_scr_w <= SIZE_W'(1920);
            r_scr_h <= SIZE_W'(1080);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ROW_X_XY: r_rx_xy <= i_cfg_data;
                CFG_ROW_X_ZT: r_rx_zt <= i_cfg_data;
                CFG_ROW_Y_XY: r_ry_xy <= i_cfg_data;
                CFG_ROW_Y_ZT: r_ry_zt <= i_cfg_data;
                CFG_ROW_W_XY: r_rw_xy <= i_cfg_data;
                CFG_ROW_W_ZT: r_rw_zt <= i_cfg_data;
                CFG_SCR_W:    r_scr_w <= i_cfg_data[SIZE_W-1:0];
                CFG_SCR_H:    r_scr_h <= i_cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // global advance: move when the result slot is free or being taken
    logic            w_adv;
    logic [NSTG-1:0] r_vld;

    assign w_adv      = !r_vld[NSTG-1] || i_m_tready;
    assign o_s_tready = w_adv;
    assign o_m_tvalid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NSTG-2:0], i_s_tvalid};
        end
    end

    // stage 1: nine products, translations carried
    logic signed [CRD_W-1:0] w_x, w_y, w_z;
    assign w_x = i_s_tdata[CRD_W-1:0];
    assign w_y = i_s_tdata[2*CRD_W-1:CRD_W];
    assign w_z = i_s_tdata[3*CRD_W-1:2*CRD_W];

    logic signed [PROD_W-1:0] r_p [0:2][0:2];
    logic signed [CRD_W-1:0]  r_t [0:2];
    logic [63:0]              w_xy [0:2];
    logic [63:0]              w_zt [0:2];

    assign w_xy[0] = r_rx_xy;
    assign w_xy[1] = r_ry_xy;
    assign w_xy[2] = r_rw_xy;
    assign w_zt[0] = r_rx_zt;
    assign w_zt[1] = r_ry_zt;
    assign w_zt[2] = r_rw_zt;

    for (genvar r = 0; r < 3; r++) begin : g_row
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_p[r][0] <= $signed(w_xy[r][31:0])  * w_x;
                r_p[r][1] <= $signed(w_xy[r][63:32]) * w_y;
                r_p[r][2] <= $signed(w_zt[r][31:0])  * w_z;
                r_t[r]    <= $signed(w_zt[r][63:32]);
            end
        end
    end

    // stage 2: floor to q16 and pairwise sums
    logic signed [CLIP_W-1:0] r_sa [0:2];
    logic signed [CLIP_W-1:0] r_sb [0:2];
    // stage 3: clip x, y, w
    logic signed [CLIP_W-1:0] r_clip [0:2];

    for (genvar r = 0; r < 3; r++) begin : g_sum
        logic signed [FLR_W-1:0] w_f0, w_f1, w_f2;
        assign w_f0 = FLR_W'(r_p[r][0] >>> 16);
        assign w_f1 = FLR_W'(r_p[r][1] >>> 16);
        assign w_f2 = FLR_W'(r_p[r][2] >>> 16);
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_sa[r]   <= CLIP_W'(w_f0) + CLIP_W'(w_f1);
                r_sb[r]   <= CLIP_W'(w_f2) + CLIP_W'(r_t[r]);
                r_clip[r] <= r_sa[r] + r_sb[r];
            end
        end
    end

    // scale units for x and y
    logic signed [TERM_W-1:0] w_term_x, w_term_y;

    wsp_scale u_scale_x (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_clip (r_clip[0]),
        .i_w    (r_clip[2]),
        .i_size (r_scr_w),
        .o_term (w_term_x)
    );

    wsp_scale u_scale_y (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_clip (r_clip[1]),
        .i_w    (r_clip[2]),
        .i_size (r_scr_h),
        .o_term (w_term_y)
    );

    // visibility travels beside the scale units
    logic r_vis [0:DIV_LAT-1];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_vis[0] <= r_clip[2] >= VIS_LIMIT;
        end
    end

    for (genvar k = 1; k < DIV_LAT; k++) begin : g_vis
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_vis[k] <= r_vis[k-1];
            end
        end
    end

    // final stage: center plus term plus half a pixel for x, minus both for y, saturate
    logic signed [SUM_W-1:0] w_cx, w_cy, w_sx, w_sy;
    assign w_cx = $signed(SUM_W'({r_scr_w[SIZE_W-1:1], 16'b0}));
    assign w_cy = $signed(SUM_W'({r_scr_h[SIZE_W-1:1], 16'b0}));
    assign w_sx = w_cx + SUM_W'(w_term_x) + HALF_PIX;
    assign w_sy = w_cy - SUM_W'(w_term_y) - HALF_PIX;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            o_m_tuser <= r_vis[DIV_LAT-1];
            o_m_tdata <= r_vis[DIV_LAT-1] ? {sat32(w_sy), sat32(w_sx)} : '0;
        end
    end

    // a hidden point carries zero coordinates
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata == '0))
        else $error("hidden point with nonzero coordinates");

    // a waiting result holds the whole pipeline
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |-> !o_s_tready)
        else $error("request taken while result stalled");

    // reset empties the pipeline
    assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // a stalled pipeline keeps its valid pattern
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |=> $stable(r_vld))
        else $error("valid bits moved during stall");

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// self-checking testbench for world_to_screen_projection
// depends on wsp_pkg and the block rtl; projects points with its own model and compares

module tb;
    import wsp_pkg::*;

    typedef struct {
        logic        vis;
        logic [31:0] sx;
        logic [31:0] sy;
    } t_pixel;

    // directed request, with a typed-in result where it is obvious
    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        bit          known;
        t_pixel      res;
    } t_point_row;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 60;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [95:0] i_s_tdata;      // world_x, world_y, world_z
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [63:0] o_m_tdata;      // screen_x, screen_y
    logic        o_m_tuser;      // visible
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [63:0] i_cfg_data;

    // shadow copy of the matrix and viewport registers
    logic [63:0] mat_reg [0:5];
    logic [13:0] view_w;
    logic [13:0] view_h;

    t_pixel pixel_q[$];
    int     n_fail = 0;
    int     n_cycle = 0;
    bit     calm;         // no idling on either side
    bit     hold_go;      // ask the receiver for one long hold-off
    bit     hold_done;
    int     hold_cnt;

    world_to_screen_projection dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------- prediction ----------------

    // one matrix row dotted with the point, each product floored to q16.16
    function automatic longint clip_row(logic [63:0] xy, logic [63:0] zt,
                                        longint x, longint y, longint z);
        longint acc;
        acc = (longint'($signed(xy[31:0])) * x) >>> 16;
        acc += (longint'($signed(xy[63:32])) * y) >>> 16;
        acc += (longint'($signed(zt[31:0])) * z) >>> 16;
        acc += longint'($signed(zt[63:32]));
        return acc;
    endfunction

    // sign(c) * trunc(|c| * size * 2^15 / w), magnitude clamped at 2^40
    function automatic longint persp_term(longint c, logic [13:0] size, longint w);
        logic [63:0] mag;
        logic [63:0] num;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] lim;
        mag = (c < 0) ? 64'(-c) : 64'(c);
        num = mag * 64'(size);
        q   = num / 64'(w);
        r   = num % 64'(w);
        lim = 64'd1 << 40;
        if (q >= lim) begin
            q = lim;
        end else begin
            for (int i = 0; i < 15; i++) begin
                q = q << 1;
                r = r << 1;
                if (r >= 64'(w)) begin
                    r = r - 64'(w);
                    q[0] = 1'b1;
                end
                if (q >= lim) begin
                    q = lim;
                    break;
                end
            end
        end
        return (c < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic t_pixel project_point(logic [31:0] px, logic [31:0] py,
                                             logic [31:0] pz);
        longint x;
        longint y;
        longint z;
        longint cx;
        longint cy;
        longint cw;
        t_pixel p;
        x  = longint'($signed(px));
        y  = longint'($signed(py));
        z  = longint'($signed(pz));
        cx = clip_row(mat_reg[0], mat_reg[1], x, y, z);
        cy = clip_row(mat_reg[2], mat_reg[3], x, y, z);
        cw = clip_row(mat_reg[4], mat_reg[5], x, y, z);
        p = '{vis: 1'b0, sx: 32'd0, sy: 32'd0};
        if (cw >= 655) begin
            p.vis = 1'b1;
            p.sx  = clamp32(longint'(view_w >> 1) * 65536
                            + persp_term(cx, view_w, cw) + 32768);
            p.sy  = clamp32(longint'(view_h >> 1) * 65536
                            - persp_term(cy, view_h, cw) - 32768);
        end
        return p;
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic bit idle_roll();
        return !calm && ($urandom_range(0, 99) < 7);
    endfunction

    // register write; the caller lowers the write enable after the last one
    task automatic reg_write(t_cfg_idx idx, logic [63:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_SCR_W: view_w = val[13:0];
            CFG_SCR_H: view_h = val[13:0];
            default:   mat_reg[idx] = val;
        endcase
    endtask

    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                              bit known, t_pixel res);
        if (idle_roll()) begin
            i_s_tvalid <= 1'b0;
            do @(posedge i_clk); while (idle_roll());
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {z, y, x};
        do @(posedge i_clk); while (!o_s_tready);
        pixel_q.push_back(known ? res : project_point(x, y, z));
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_fix(int unsigned span);
        return 32'($signed($urandom_range(0, 2 * span)) - $signed(span));
    endfunction

    // ---------------- receiver side ----------------

    always @(posedge i_clk) begin
        n_cycle <= n_cycle + 1;
        if (n_cycle > CYCLE_LIMIT) begin
            $display("%0t timeout with %0d results pending", $time, pixel_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ready pattern: random stalls, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            hold_cnt   <= 0;
            hold_done  <= 1'b0;
        end else if (hold_go && !hold_done) begin
            i_m_tready <= 1'b0;
            hold_cnt   <= hold_cnt + 1;
            if (hold_cnt == 300) hold_done <= 1'b1;
        end else begin
            i_m_tready <= !idle_roll();
        end
    end

    // compare each result with the oldest pending prediction
    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pixel_q.size() == 0) begin
                $display("%0t unexpected result vis=%0b x=%h y=%h", $time,
                         o_m_tuser, o_m_tdata[31:0], o_m_tdata[63:32]);
                n_fail++;
            end else begin
                want = pixel_q.pop_front();
                if (want.vis !== o_m_tuser) begin
                    $display("%0t visible exp %0b got %0b", $time, want.vis, o_m_tuser);
                    n_fail++;
                end
                if (want.sx !== o_m_tdata[31:0]) begin
                    $display("%0t screen_x exp %h got %h", $time, want.sx,
                             o_m_tdata[31:0]);
                    n_fail++;
                end
                if (want.sy !== o_m_tdata[63:32]) begin
                    $display("%0t screen_y exp %h got %h", $time, want.sy,
                             o_m_tdata[63:32]);
                    n_fail++;
                end
            end
        end
    end

    // ---------------- main sequence ----------------

    t_point_row boot_rows [0:3];
    t_point_row unit_rows [0:11];

    initial begin
        t_pixel      dummy;
        t_pixel      hidden;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic [13:0] sw;
        logic [13:0] sh;
        int unsigned span;

        calm       = 1'b0;
        hold_go    = 1'b0;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_ROW_X_XY;
        i_cfg_data = '0;
        for (int i = 0; i < 6; i++) mat_reg[i] = '0;
        view_w = 14'd1920;
        view_h = 14'd1080;
        dummy  = '{vis: 1'b0, sx: 32'd0, sy: 32'd0};
        hidden = dummy;

        // after reset every matrix row is zero, so w is zero and nothing is visible
        boot_rows[0] = '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1, hidden};
        boot_rows[1] = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, hidden};
        boot_rows[2] = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, hidden};
        boot_rows[3] = '{32'hFFFF_FFFF, 32'h0001_0000, 32'h8000_0001, 1, hidden};

        // identity x and y, w = z, 1920 x 1080 viewport
        unit_rows[0]  = '{32'h0, 32'h0, 32'h0001_0000, 1,
                          '{1'b1, 32'h03C0_8000, 32'h021B_8000}};
        unit_rows[1]  = '{32'h0001_0000, 32'h0, 32'h0001_0000, 1,
                          '{1'b1, 32'h0780_8000, 32'h021B_8000}};
        unit_rows[2]  = '{32'h0, 32'h0001_0000, 32'h0001_0000, 1,
                          '{1'b1, 32'h03C0_8000, 32'hFFFF_8000}};
        // w just below and at the visibility limit
        unit_rows[3]  = '{32'h0, 32'h0, 32'd654, 1, hidden};
        unit_rows[4]  = '{32'h0, 32'h0, 32'd655, 1,
                          '{1'b1, 32'h03C0_8000, 32'h021B_8000}};
        // far corners saturate
        unit_rows[5]  = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0001_0000, 1,
                          '{1'b1, 32'h7FFF_FFFF, 32'h8000_0000}};
        unit_rows[6]  = '{32'h8000_0000, 32'h8000_0000, 32'h0001_0000, 1,
                          '{1'b1, 32'h8000_0000, 32'h7FFF_FFFF}};
        // negative or zero depth is behind the camera
        unit_rows[7]  = '{32'h0001_0000, 32'h0001_0000, 32'h8000_0000, 1, hidden};
        unit_rows[8]  = '{32'h0001_0000, 32'h0001_0000, 32'h0, 1, hidden};
        unit_rows[9]  = '{32'h0003_8000, 32'hFFFD_4000, 32'h7FFF_FFFF, 0, dummy};
        unit_rows[10] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'd655, 0, dummy};
        unit_rows[11] = '{32'hFFFF_0001, 32'h0000_FFFF, 32'h0002_0000, 0, dummy};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (boot_rows[i])
            send_point(boot_rows[i].x, boot_rows[i].y, boot_rows[i].z,
                       boot_rows[i].known, boot_rows[i].res);
        wait_drained();

        reg_write(CFG_ROW_X_XY, 64'h0000_0000_0001_0000);
        reg_write(CFG_ROW_X_ZT, 64'h0);
        reg_write(CFG_ROW_Y_XY, 64'h0001_0000_0000_0000);
        reg_write(CFG_ROW_Y_ZT, 64'h0);
        reg_write(CFG_ROW_W_XY, 64'h0);
        reg_write(CFG_ROW_W_ZT, 64'h0000_0000_0001_0000);
        i_cfg_we <= 1'b0;
        foreach (unit_rows[i])
            send_point(unit_rows[i].x, unit_rows[i].y, unit_rows[i].z,
                       unit_rows[i].known, unit_rows[i].res);
        wait_drained();

        // random phases, each with its own matrix and viewport
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin sw = 14'd1920;  sh = 14'd1080;  end
                1: begin sw = 14'd0;     sh = 14'd16383; end
                2: begin sw = 14'd1;     sh = 14'd1;     end
                3: begin sw = 14'd8192;  sh = 14'd8192;  end
                4: begin sw = 14'd16383; sh = 14'd0;     end
                default: begin
                    sw = 14'($urandom_range(1, 8192));
                    sh = 14'($urandom_range(1, 8192));
                end
            endcase
            // upper data bits are don't-care for the viewport registers
            reg_write(CFG_SCR_W, {$urandom, 18'($urandom), sw});
            reg_write(CFG_SCR_H, {$urandom, 18'($urandom), sh});
            if (ph == 2) begin
                // fully random matrix, mostly invisible or saturating
                reg_write(CFG_ROW_X_XY, {$urandom, $urandom});
                reg_write(CFG_ROW_X_ZT, {$urandom, $urandom});
                reg_write(CFG_ROW_Y_XY, {$urandom, $urandom});
                reg_write(CFG_ROW_Y_ZT, {$urandom, $urandom});
                reg_write(CFG_ROW_W_XY, {$urandom, $urandom});
                reg_write(CFG_ROW_W_ZT, {$urandom, $urandom});
            end else begin
                // coefficients within +-4.0, translations within +-64.0, w row biased to sit in front
                reg_write(CFG_ROW_X_XY, {rand_fix(32'h4_0000), rand_fix(32'h4_0000)});
                reg_write(CFG_ROW_X_ZT, {rand_fix(32'h40_0000), rand_fix(32'h4_0000)});
                reg_write(CFG_ROW_Y_XY, {rand_fix(32'h4_0000), rand_fix(32'h4_0000)});
                reg_write(CFG_ROW_Y_ZT, {rand_fix(32'h40_0000), rand_fix(32'h4_0000)});
                reg_write(CFG_ROW_W_XY, {rand_fix(32'h8000), rand_fix(32'h8000)});
                reg_write(CFG_ROW_W_ZT, {32'($urandom_range(32'h100, 32'h100_0000)),
                                         rand_fix(32'h1_0000)});
            end
            i_cfg_we <= 1'b0;

            calm    = (ph == 4);
            hold_go <= (ph == 1);
            for (int n = 0; n < 100; n++) begin
                // one mid-phase pause until the pipeline has emptied
                if (ph == 3 && n == 50) wait_drained();
                span = ($urandom_range(0, 99) < 85) ? 32'h40_0000 : 32'h7FFF_FFFF;
                if (span == 32'h7FFF_FFFF) begin
                    px = $urandom;
                    py = $urandom;
                    pz = $urandom;
                end else begin
                    px = rand_fix(span);
                    py = rand_fix(span);
                    pz = rand_fix(span);
                end
                send_point(px, py, pz, 0, dummy);
            end
            wait_drained();
            calm = 1'b0;
        end

        if (n_fail == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
